// ===== src/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// shared constants and types of the segment intersection test
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // sign of a product sum or difference
    typedef struct packed {
        logic pos;
        logic neg;
    } t_sign;

    // load enables of the product and sign stages
    typedef struct packed {
        logic prod;
        logic sgn;
    } t_lane_en;

endpackage

// ===== src/sit_lane.sv =====
// ----------------------------------------------------------------------------
// sit_lane
// two products of difference vectors, then the sign of their difference
// (cross product) or sum (dot product), one register stage each
// ----------------------------------------------------------------------------
module sit_lane
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter bit IS_DOT      = 1'b0
) (
    input  logic                   i_clk,
    input  t_lane_en               i_en,
    input  logic signed [COORD_WIDTH:0] i_ux,
    input  logic signed [COORD_WIDTH:0] i_uy,
    input  logic signed [COORD_WIDTH:0] i_vx,
    input  logic signed [COORD_WIDTH:0] i_vy,
    output t_sign                  o_sign
);

    localparam int PW = 2 * COORD_WIDTH + 2;

    logic signed [PW-1:0] r_p;
    logic signed [PW-1:0] r_q;
    logic signed [PW-1:0] n_p;
    logic signed [PW-1:0] n_q;
    logic signed [PW:0]   w_res;
    t_sign                r_sign;
    t_sign                n_sign;

    always_comb begin
        if (IS_DOT) begin
            n_p = i_ux * i_vx;
            n_q = i_uy * i_vy;
        end else begin
            n_p = i_ux * i_vy;
            n_q = i_uy * i_vx;
        end
    end

    always_comb begin
        if (IS_DOT) begin
            w_res = $signed({r_p[PW-1], r_p}) + $signed({r_q[PW-1], r_q});
        end else begin
            w_res = $signed({r_p[PW-1], r_p}) - $signed({r_q[PW-1], r_q});
        end
        n_sign.neg = w_res[PW];
        n_sign.pos = !w_res[PW] && (w_res != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_p <= n_p;
            r_q <= n_q;
        end
        if (i_en.sgn) begin
            r_sign <= n_sign;
        end
    end

    assign o_sign = r_sign;

endmodule

// ===== src/segment_intersection_test.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_test
// tells whether two closed segments ab and cd share at least one point
// ----------------------------------------------------------------------------
//  channel | dir | tdata (lsb first)                      | tuser | tlast
//  s       | in  | a_x a_y b_x b_y c_x c_y d_x d_y        | -     | -
//  m       | out | intersects, zero padded to 8 bits      | -     | -
//
// one transaction per cycle while the output is not stalled
// stages: differences, products, product signs, final decision
// synchronous active-low reset clears the stage valid bits only
// a stalled output holds its stage, earlier stages keep filling bubbles
// ----------------------------------------------------------------------------
module segment_intersection_test
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_W = ((8 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [IN_W-1:0]            i_s_tdata,   // a_x a_y b_x b_y c_x c_y d_x d_y
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata    // intersects, padding
);

    localparam int DW   = COORD_WIDTH + 1;

    // difference vector slots
    localparam int BA = 0;
    localparam int CA = 1;
    localparam int DA = 2;
    localparam int DC = 3;
    localparam int AC = 4;
    localparam int BC = 5;
    localparam int BD = 6;
    localparam int DB = 7;

    logic signed [COORD_WIDTH-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy, w_dx, w_dy;

    logic signed [DW-1:0] r_vx [8];
    logic signed [DW-1:0] r_vy [8];
    logic signed [DW-1:0] n_vx [8];
    logic signed [DW-1:0] n_vy [8];

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;
    logic r_hit;
    logic n_hit;

    t_lane_en w_len;
    t_sign    w_s   [4];
    t_sign    w_oc  [4];
    t_sign    w_od  [4];

    function automatic logic signed [DW-1:0] f_diff(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [COORD_WIDTH-1:0] q
    );
        f_diff = $signed({p[COORD_WIDTH-1], p}) - $signed({q[COORD_WIDTH-1], q});
    endfunction

    assign w_ax = i_s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign w_ay = i_s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign w_bx = i_s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign w_by = i_s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign w_cx = i_s_tdata[4*COORD_WIDTH +: COORD_WIDTH];
    assign w_cy = i_s_tdata[5*COORD_WIDTH +: COORD_WIDTH];
    assign w_dx = i_s_tdata[6*COORD_WIDTH +: COORD_WIDTH];
    assign w_dy = i_s_tdata[7*COORD_WIDTH +: COORD_WIDTH];

    always_comb begin
        n_vx[BA] = f_diff(w_bx, w_ax);  n_vy[BA] = f_diff(w_by, w_ay);
        n_vx[CA] = f_diff(w_cx, w_ax);  n_vy[CA] = f_diff(w_cy, w_ay);
        n_vx[DA] = f_diff(w_dx, w_ax);  n_vy[DA] = f_diff(w_dy, w_ay);
        n_vx[DC] = f_diff(w_dx, w_cx);  n_vy[DC] = f_diff(w_dy, w_cy);
        n_vx[AC] = f_diff(w_ax, w_cx);  n_vy[AC] = f_diff(w_ay, w_cy);
        n_vx[BC] = f_diff(w_bx, w_cx);  n_vy[BC] = f_diff(w_by, w_cy);
        n_vx[BD] = f_diff(w_bx, w_dx);  n_vy[BD] = f_diff(w_by, w_dy);
        n_vx[DB] = f_diff(w_dx, w_bx);  n_vy[DB] = f_diff(w_dy, w_by);
    end

    // stage enables, a stage loads when empty or when its successor moves
    assign w_en4 = !r_v4 || i_m_tready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign w_len.prod = w_en2;
    assign w_len.sgn  = w_en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_s_tvalid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_vx <= n_vx;
            r_vy <= n_vy;
        end
        if (w_en4) begin
            r_hit <= n_hit;
        end
    end

    // orientation of c, d against ab and of a, b against cd
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b0)) u_s1 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[BA]), .i_uy(r_vy[BA]), .i_vx(r_vx[CA]), .i_vy(r_vy[CA]),
        .o_sign(w_s[0])
    );
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b0)) u_s2 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[BA]), .i_uy(r_vy[BA]), .i_vx(r_vx[DA]), .i_vy(r_vy[DA]),
        .o_sign(w_s[1])
    );
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b0)) u_s3 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[DC]), .i_uy(r_vy[DC]), .i_vx(r_vx[AC]), .i_vy(r_vy[AC]),
        .o_sign(w_s[2])
    );
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b0)) u_s4 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[DC]), .i_uy(r_vy[DC]), .i_vx(r_vx[BC]), .i_vy(r_vy[BC]),
        .o_sign(w_s[3])
    );

    // endpoint on segment: c on ab, d on ab, a on cd, b on cd
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b0)) u_oc1 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[CA]), .i_uy(r_vy[CA]), .i_vx(r_vx[BC]), .i_vy(r_vy[BC]),
        .o_sign(w_oc[0])
    );
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b1)) u_od1 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[CA]), .i_uy(r_vy[CA]), .i_vx(r_vx[BC]), .i_vy(r_vy[BC]),
        .o_sign(w_od[0])
    );
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b0)) u_oc2 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[DA]), .i_uy(r_vy[DA]), .i_vx(r_vx[BD]), .i_vy(r_vy[BD]),
        .o_sign(w_oc[1])
    );
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b1)) u_od2 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[DA]), .i_uy(r_vy[DA]), .i_vx(r_vx[BD]), .i_vy(r_vy[BD]),
        .o_sign(w_od[1])
    );
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b0)) u_oc3 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[AC]), .i_uy(r_vy[AC]), .i_vx(r_vx[DA]), .i_vy(r_vy[DA]),
        .o_sign(w_oc[2])
    );
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b1)) u_od3 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[AC]), .i_uy(r_vy[AC]), .i_vx(r_vx[DA]), .i_vy(r_vy[DA]),
        .o_sign(w_od[2])
    );
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b0)) u_oc4 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[BC]), .i_uy(r_vy[BC]), .i_vx(r_vx[DB]), .i_vy(r_vy[DB]),
        .o_sign(w_oc[3])
    );
    sit_lane #(.COORD_WIDTH(COORD_WIDTH), .IS_DOT(1'b1)) u_od4 (
        .i_clk(i_clk), .i_en(w_len),
        .i_ux(r_vx[BC]), .i_uy(r_vy[BC]), .i_vx(r_vx[DB]), .i_vy(r_vy[DB]),
        .o_sign(w_od[3])
    );

    always_comb begin
        logic w_zero;
        logic w_on;
        logic w_ab_ok;
        logic w_cd_ok;
        w_zero = 1'b1;
        w_on   = 1'b0;
        for (int k = 0; k < 4; k++) begin
            w_zero = w_zero && !w_s[k].pos && !w_s[k].neg;
            w_on   = w_on || (!w_oc[k].pos && !w_oc[k].neg && !w_od[k].neg);
        end
        w_ab_ok = !(w_s[0].pos && w_s[1].pos) && !(w_s[0].neg && w_s[1].neg);
        w_cd_ok = !(w_s[2].pos && w_s[3].pos) && !(w_s[2].neg && w_s[3].neg);
        n_hit   = w_zero ? w_on : (w_ab_ok && w_cd_ok);
    end

    assign o_s_tready = w_en1;
    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = {7'b0, r_hit};

endmodule

// ===== src/sit_checker.sv =====
// ----------------------------------------------------------------------------
// sit_checker
// port-level checks of the segment intersection test
// ----------------------------------------------------------------------------
module sit_checker
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    input  logic                                    o_s_tready,
    input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]      i_s_tdata,
    input  logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    input  logic [7:0]                              o_m_tdata
);

    // output held while stalled
    a_m_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output transaction dropped or changed while stalled");

    // input offered until taken
    a_s_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=> i_s_tvalid && $stable(i_s_tdata))
        else $error("input transaction withdrawn or changed while stalled");

    // padding stays zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:1] == 7'b0)
        else $error("output padding not zero");

    // fixed latency through a free-running pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) ##1 i_m_tready ##1 i_m_tready ##1 i_m_tready
        |=> o_m_tvalid)
        else $error("result missing four cycles after input transaction");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind segment_intersection_test sit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sit_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
